// File: src/fmti_pkg.sv
// Shared types and constants for the trilinear field-map lookup.
// No dependencies; used by every module of the block.
`default_nettype none

package fmti_pkg;

    localparam int ADDR_W = 16;
    localparam int FRAC_W = 17;
    localparam int CFG_AW = 5;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_INV_X = 3'd3;
    localparam logic [2:0] REG_INV_Y = 3'd4;
    localparam logic [2:0] REG_INV_Z = 3'd5;

    localparam logic [2:0] TAG_E0    = 3'd4;
    localparam logic [2:0] TAG_E1    = 3'd5;
    localparam logic [2:0] TAG_FINAL = 3'd6;

    typedef struct packed {
        logic               op;
        logic [15:0]        entry_index;
        logic signed [31:0] load_bx;
        logic signed [31:0] load_by;
        logic signed [31:0] load_bz;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
        logic               inside_res;
    } out_t;

    typedef struct packed {
        logic [30:0]        min_x;
        logic [30:0]        min_y;
        logic signed [31:0] min_z;
        logic [31:0]        inv_step_x;
        logic [31:0]        inv_step_y;
        logic [31:0]        inv_step_z;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
    } field_t;

    typedef struct packed {
        logic              query;
        logic              in_grid;
        logic [ADDR_W-1:0] addr;
        logic [FRAC_W-1:0] fx;
        logic [FRAC_W-1:0] fy;
        logic [FRAC_W-1:0] fz;
        field_t            data;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_AXIS,
        F_ADDR,
        F_PUSH
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_RUN
    } back_state_t;

    typedef enum logic [1:0] {
        SRC_MEM,
        SRC_C01,
        SRC_C23,
        SRC_E01
    } lerp_src_t;

    typedef struct packed {
        logic              issue;
        lerp_src_t         src;
        logic [FRAC_W-1:0] f;
        logic [2:0]        tag;
    } lerp_ctl_t;

endpackage

`default_nettype wire

// File: src/fmti_front.sv
// Front end: accepts words, maps a query point to grid indexes and fractions.
// Depends on fmti_pkg; feeds jobs to fmti_queue.
`default_nettype none

module fmti_front #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  fmti_pkg::in_t      cmd,
    input  fmti_pkg::cfg_t     cfg,
    output logic               push,
    output fmti_pkg::job_t     push_job,
    input  wire logic          full
);
    import fmti_pkg::*;

    localparam int XW = $clog2(GRID_X);
    localparam int YW = $clog2(GRID_Y);
    localparam int ZW = $clog2(GRID_Z);
    localparam logic [63:0] LAST_X = 64'(GRID_X - 1) << 16;
    localparam logic [63:0] LAST_Y = 64'(GRID_Y - 1) << 16;
    localparam logic [63:0] LAST_Z = 64'(GRID_Z - 1) << 16;

    front_state_t state_reg, state_next;
    logic [2:0]   cnt_reg, cnt_next;

    in_t               cmd_reg;
    logic [33:0]       d_reg;
    logic [63:0]       t_reg;
    logic              tneg_reg;
    logic              inside_reg;
    logic [XW-1:0]     ix_reg;
    logic [YW-1:0]     iy_reg;
    logic [ZW-1:0]     iz_reg;
    logic [FRAC_W-1:0] fx_reg;
    logic [FRAC_W-1:0] fy_reg;
    logic [FRAC_W-1:0] fz_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic        accept;
    logic [31:0] abs_x;
    logic [31:0] abs_y;
    logic [33:0] d_x;
    logic [33:0] d_y;
    logic [33:0] d_z;
    logic [33:0] d_sel;
    logic [31:0] inv_sel;
    logic [63:0] prod;
    logic [63:0] last_sel;
    logic        ok;
    logic        at_top;
    logic [31:0] lin;

    assign accept = start && !busy;

    always_comb
    begin
        abs_x = cmd_reg.pos_x[31] ? (~cmd_reg.pos_x + 32'd1) : cmd_reg.pos_x;
        abs_y = cmd_reg.pos_y[31] ? (~cmd_reg.pos_y + 32'd1) : cmd_reg.pos_y;
        d_x   = {2'b00, abs_x} - {3'b000, cfg.min_x};
        d_y   = {2'b00, abs_y} - {3'b000, cfg.min_y};
        d_z   = {{2{cmd_reg.pos_z[31]}}, cmd_reg.pos_z} - {{2{cfg.min_z[31]}}, cfg.min_z};
        case (cnt_reg)
            3'd0:    d_sel = d_x;
            3'd1:    d_sel = d_y;
            default: d_sel = d_z;
        endcase
        case (cnt_reg)
            3'd1:    inv_sel = cfg.inv_step_x;
            3'd2:    inv_sel = cfg.inv_step_y;
            default: inv_sel = cfg.inv_step_z;
        endcase
        prod = 64'(d_reg[31:0]) * 64'(inv_sel);
        case (cnt_reg)
            3'd2:    last_sel = LAST_X;
            3'd3:    last_sel = LAST_Y;
            default: last_sel = LAST_Z;
        endcase
        ok     = !tneg_reg && (t_reg <= last_sel);
        at_top = (t_reg == last_sel);
        lin    = (32'(ix_reg) * 32'(GRID_Y) + 32'(iy_reg)) * 32'(GRID_Z) + 32'(iz_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            F_IDLE:
            begin
                cnt_next = 3'd0;
                if (start)
                begin
                    state_next = (cmd.op == OP_QUERY) ? F_AXIS : F_PUSH;
                end
            end
            F_AXIS:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd4)
                begin
                    state_next = F_ADDR;
                end
            end
            F_ADDR:
            begin
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy = (state_reg != F_IDLE);
        push = (state_reg == F_PUSH) && !full;
        push_job.query   = (cmd_reg.op == OP_QUERY);
        push_job.in_grid = inside_reg;
        push_job.addr    = (cmd_reg.op == OP_QUERY) ? addr_reg : cmd_reg.entry_index;
        push_job.fx      = fx_reg;
        push_job.fy      = fy_reg;
        push_job.fz      = fz_reg;
        push_job.data    = '{bx: cmd_reg.load_bx, by: cmd_reg.load_by, bz: cmd_reg.load_bz};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            inside_reg <= 1'b1;
        end
        if (state_reg == F_AXIS)
        begin
            if (cnt_reg < 3'd3)
            begin
                d_reg <= d_sel;
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd3)
            begin
                t_reg    <= prod;
                tneg_reg <= d_reg[33];
            end
            if (cnt_reg >= 3'd2)
            begin
                inside_reg <= inside_reg & ok;
                case (cnt_reg)
                    3'd2:
                    begin
                        ix_reg <= at_top ? XW'(GRID_X - 2) : t_reg[16 +: XW];
                        fx_reg <= at_top ? FRAC_ONE : {1'b0, t_reg[15:0]};
                    end
                    3'd3:
                    begin
                        iy_reg <= at_top ? YW'(GRID_Y - 2) : t_reg[16 +: YW];
                        fy_reg <= at_top ? FRAC_ONE : {1'b0, t_reg[15:0]};
                    end
                    default:
                    begin
                        iz_reg <= at_top ? ZW'(GRID_Z - 2) : t_reg[16 +: ZW];
                        fz_reg <= at_top ? FRAC_ONE : {1'b0, t_reg[15:0]};
                    end
                endcase
            end
        end
        if (state_reg == F_ADDR)
        begin
            addr_reg <= lin[ADDR_W-1:0];
        end
    end

endmodule

`default_nettype wire

// File: src/fmti_queue.sv
// Two-entry job queue between the front end and the back end.
// Depends on fmti_pkg for the job type.
`default_nettype none

module fmti_queue (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  fmti_pkg::job_t push_job,
    output logic           full,
    input  wire logic      pop,
    output fmti_pkg::job_t pop_job,
    output logic           empty
);
    import fmti_pkg::*;

    job_t       q_reg [0:1];
    logic       wr_reg, wr_next;
    logic       rd_reg, rd_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        full       = (count_reg == 2'd2);
        empty      = (count_reg == 2'd0);
        pop_job    = q_reg[rd_reg];
        wr_next    = push ? ~wr_reg : wr_reg;
        rd_next    = pop ? ~rd_reg : rd_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// File: src/fmti_back.sv
// Back end: grid memory, corner fetch sequencer and three interpolation lanes.
// Depends on fmti_pkg; takes jobs from fmti_queue.
`default_nettype none

module fmti_back #(
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 64
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      empty,
    output logic           pop,
    input  fmti_pkg::job_t job,
    output logic           done,
    output fmti_pkg::out_t result
);
    import fmti_pkg::*;

    localparam int          DEPTH     = 1 << ADDR_W;
    localparam logic [ADDR_W-1:0] OFF_X = ADDR_W'(GRID_Y * GRID_Z);
    localparam logic [ADDR_W-1:0] OFF_Y = ADDR_W'(GRID_Z);
    localparam logic [3:0]  LAST_STEP = 4'd14;

    back_state_t state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic        done_reg, done_next;
    out_t        result_reg;
    job_t        job_reg;
    field_t      rd_reg;
    field_t      mem [0:DEPTH-1];

    logic              fin_vld_reg;
    logic [2:0]        tag_reg;
    lerp_ctl_t         ctl;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;

    logic signed [31:0] rd_c  [0:2];
    logic signed [31:0] fin_c [0:2];

    assign rd_c[0] = rd_reg.bx;
    assign rd_c[1] = rd_reg.by;
    assign rd_c[2] = rd_reg.bz;

    always_comb
    begin
        off = (step_reg[2] ? OFF_X : '0) + (step_reg[1] ? OFF_Y : '0)
            + ADDR_W'(step_reg[0]);
        mem_addr = (state_reg == B_RUN) ? (job_reg.addr + off) : job.addr;
        mem_we   = pop && !job.query;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= job.data;
        end
        rd_reg <= mem[mem_addr];
    end

    always_comb
    begin
        ctl = '{issue: 1'b0, src: SRC_MEM, f: job_reg.fz, tag: 3'd0};
        if (state_reg == B_RUN)
        begin
            case (step_reg)
                4'd2, 4'd4, 4'd6, 4'd8:
                begin
                    ctl.issue = 1'b1;
                    ctl.tag   = 3'(step_reg[3:1] - 3'd1);
                end
                4'd10:
                begin
                    ctl = '{issue: 1'b1, src: SRC_C01, f: job_reg.fy, tag: TAG_E0};
                end
                4'd11:
                begin
                    ctl = '{issue: 1'b1, src: SRC_C23, f: job_reg.fy, tag: TAG_E1};
                end
                4'd13:
                begin
                    ctl = '{issue: 1'b1, src: SRC_E01, f: job_reg.fx, tag: TAG_FINAL};
                end
                default:
                begin
                    ctl.issue = 1'b0;
                end
            endcase
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        logic signed [31:0] ev_reg;
        logic signed [31:0] v_reg [0:5];
        logic signed [31:0] a_reg;
        logic signed [50:0] prod_reg;
        logic signed [31:0] a_in;
        logic signed [31:0] b_in;
        logic signed [32:0] diff;
        logic signed [50:0] prod_next;
        logic signed [50:0] rnd;

        always_comb
        begin
            case (ctl.src)
                SRC_MEM:
                begin
                    a_in = ev_reg;
                    b_in = rd_c[k];
                end
                SRC_C01:
                begin
                    a_in = v_reg[0];
                    b_in = v_reg[1];
                end
                SRC_C23:
                begin
                    a_in = v_reg[2];
                    b_in = v_reg[3];
                end
                default:
                begin
                    a_in = v_reg[4];
                    b_in = v_reg[5];
                end
            endcase
            diff      = {b_in[31], b_in} - {a_in[31], a_in};
            prod_next = diff * $signed({1'b0, ctl.f});
            rnd       = prod_reg + 51'sd32768;
            fin_c[k]  = a_reg + rnd[47:16];
        end

        always_ff @(posedge clk)
        begin
            if (state_reg == B_RUN && step_reg[0] && step_reg <= 4'd7)
            begin
                ev_reg <= rd_c[k];
            end
            if (ctl.issue)
            begin
                a_reg    <= a_in;
                prod_reg <= prod_next;
            end
            if (fin_vld_reg && tag_reg != TAG_FINAL)
            begin
                v_reg[tag_reg] <= fin_c[k];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            B_IDLE:
            begin
                step_next = 4'd0;
                if (!empty && job.query && job.in_grid)
                begin
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                step_next = step_reg + 4'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop       = (state_reg == B_IDLE) && !empty;
        done_next = (pop && job.query && !job.in_grid)
                 || (fin_vld_reg && tag_reg == TAG_FINAL);
        done      = done_reg;
        result    = result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            step_reg    <= 4'd0;
            done_reg    <= 1'b0;
            fin_vld_reg <= 1'b0;
            tag_reg     <= 3'd0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            done_reg    <= done_next;
            fin_vld_reg <= ctl.issue;
            tag_reg     <= ctl.tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= job;
        end
        if (fin_vld_reg && tag_reg == TAG_FINAL)
        begin
            result_reg <= '{field_x: fin_c[0], field_y: fin_c[1], field_z: fin_c[2],
                            inside_res: 1'b1};
        end
        else if (pop && job.query && !job.in_grid)
        begin
            result_reg <= '{field_x: 32'sd0, field_y: 32'sd0, field_z: 32'sd0,
                            inside_res: 1'b0};
        end
    end

endmodule

`default_nettype wire

// File: src/field_map_trilinear_interp.sv
// Top level of the trilinear field-map lookup: register port and block wiring.
// Depends on fmti_pkg, fmti_front, fmti_queue and fmti_back.
//
// Command channel: a word (cmd) is taken at a clock edge with start high and
// busy low. Op write stores one grid entry and gives no result; op query
// gives one result word on result, marked by done for exactly one cycle.
// Registers are to be written over the APB-style port only while the block is
// idle; the block itself does not enforce this. A write word holds busy through
// the push state; a query through the axis steps (three axes through one shared
// 32x32 multiplier), the address step and the push state, which waits while the
// queue is full. A two-entry queue decouples this front end from the back end.
// The back end fetches the eight corners one a cycle from the single-port
// grid memory and blends them in three lanes; an inside query occupies it from
// its pop through all run steps, so it takes no new job until the run ends; a
// write or an outside query takes only its pop.
// The receiver cannot stall; done is a pure strobe.
// Reset clears the registers to zero and empties the queue; grid contents
// are undefined until written.
`default_nettype none

module field_map_trilinear_interp #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  fmti_pkg::in_t               cmd,
    output logic                        done,
    output fmti_pkg::out_t              result,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [fmti_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import fmti_pkg::*;

    cfg_t cfg_reg;
    logic [2:0] reg_idx;
    logic       cfg_we;

    logic push;
    job_t push_job;
    logic full;
    logic pop;
    job_t pop_job;
    logic empty;

    assign reg_idx = paddr[CFG_AW-1:2];
    assign cfg_we  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (reg_idx)
                REG_MIN_X: cfg_reg.min_x      <= pwdata[30:0];
                REG_MIN_Y: cfg_reg.min_y      <= pwdata[30:0];
                REG_MIN_Z: cfg_reg.min_z      <= pwdata;
                REG_INV_X: cfg_reg.inv_step_x <= pwdata;
                REG_INV_Y: cfg_reg.inv_step_y <= pwdata;
                REG_INV_Z: cfg_reg.inv_step_z <= pwdata;
                default:   cfg_reg            <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_X: prdata = {1'b0, cfg_reg.min_x};
            REG_MIN_Y: prdata = {1'b0, cfg_reg.min_y};
            REG_MIN_Z: prdata = cfg_reg.min_z;
            REG_INV_X: prdata = cfg_reg.inv_step_x;
            REG_INV_Y: prdata = cfg_reg.inv_step_y;
            REG_INV_Z: prdata = cfg_reg.inv_step_z;
            default:   prdata = 32'd0;
        endcase
    end

    fmti_front #(
        .GRID_X(GRID_X),
        .GRID_Y(GRID_Y),
        .GRID_Z(GRID_Z)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .push     (push),
        .push_job (push_job),
        .full     (full)
    );

    fmti_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (empty)
    );

    fmti_back #(
        .GRID_Y(GRID_Y),
        .GRID_Z(GRID_Z)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .pop    (pop),
        .job    (pop_job),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire

// File: dv/field_map_trilinear_interp_test.sv
// Testbench for field_map_trilinear_interp: writes each grid entry before a
// query first reads it, sends directed and random queries under several register
// settings and checks each result against a trilinear predictor kept here. Depends on fmti_pkg.
`timescale 1ns / 1ps

module field_map_trilinear_interp_test;
    import fmti_pkg::*;

    localparam int GX = 32;
    localparam int GY = 32;
    localparam int GZ = 64;
    localparam int DEPTH = 65536;
    localparam int CYCLE_LIMIT = 2000000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    in_t                 cmd;
    logic                done;
    out_t                result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [CFG_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    logic signed [31:0]  map_bx [0:DEPTH-1];
    logic signed [31:0]  map_by [0:DEPTH-1];
    logic signed [31:0]  map_bz [0:DEPTH-1];
    bit                  written [0:DEPTH-1];
    cfg_t                regs;
    out_t                pending_fields [$];
    int                  mismatches;
    int                  cycles;
    int                  burst_left;
    bit                  steady;

    field_map_trilinear_interp #(.GRID_X(GX), .GRID_Y(GY), .GRID_Z(GZ)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic bit locate_axis(longint d, logic [31:0] inv, int n,
                                       output int idx, output int frac);
        logic [63:0] t;
        logic [63:0] last;
        idx = 0;
        frac = 0;
        if (d < 0)
            return 1'b0;
        t = 64'(d) * {32'b0, inv};
        last = 64'(n - 1) << 16;
        if (t > last)
            return 1'b0;
        idx = int'(t >> 16);
        frac = int'(t[15:0]);
        if (idx >= n - 1)
        begin
            idx = n - 2;
            frac = 65536;
        end
        return 1'b1;
    endfunction

    function automatic longint lerp_q16(longint a, longint b, int f);
        longint p;
        p = (b - a) * longint'(f) + 64'sd32768;
        return a + (p >>> 16);
    endfunction

    function automatic longint corner(int comp, int ix, int iy, int iz);
        int a;
        a = ((ix * GY + iy) * GZ + iz) & 16'hFFFF;
        case (comp)
            0: return longint'(map_bx[a]);
            1: return longint'(map_by[a]);
            default: return longint'(map_bz[a]);
        endcase
    endfunction

    function automatic longint blend_comp(int comp, int ix, int iy, int iz,
                                          int fx, int fy, int fz);
        longint c [2][2];
        longint e [2];
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                c[i][j] = lerp_q16(corner(comp, ix + i, iy + j, iz),
                                   corner(comp, ix + i, iy + j, iz + 1), fz);
        for (int i = 0; i < 2; i++)
            e[i] = lerp_q16(c[i][0], c[i][1], fy);
        return lerp_q16(e[0], e[1], fx);
    endfunction

    function automatic bit locate_point(in_t w, output int ix, output int iy,
                                        output int iz, output int fx, output int fy,
                                        output int fz);
        longint ax;
        longint ay;
        ix = 0;
        iy = 0;
        iz = 0;
        fx = 0;
        fy = 0;
        fz = 0;
        ax = (w.pos_x < 0) ? -longint'(w.pos_x) : longint'(w.pos_x);
        ay = (w.pos_y < 0) ? -longint'(w.pos_y) : longint'(w.pos_y);
        return locate_axis(ax - longint'(regs.min_x), regs.inv_step_x, GX, ix, fx)
            && locate_axis(ay - longint'(regs.min_y), regs.inv_step_y, GY, iy, fy)
            && locate_axis(longint'(w.pos_z) - longint'(regs.min_z), regs.inv_step_z,
                           GZ, iz, fz);
    endfunction

    function automatic out_t predict_field(in_t w);
        int     ix, iy, iz, fx, fy, fz;
        out_t   r;
        r = '0;
        if (locate_point(w, ix, iy, iz, fx, fy, fz))
        begin
            r.field_x = 32'(blend_comp(0, ix, iy, iz, fx, fy, fz));
            r.field_y = 32'(blend_comp(1, ix, iy, iz, fx, fy, fz));
            r.field_z = 32'(blend_comp(2, ix, iy, iz, fx, fy, fz));
            r.inside_res = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && done)
        begin
            if (pending_fields.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: x=%0d y=%0d z=%0d inside=%0b",
                             result.field_x, result.field_y, result.field_z,
                             result.inside_res);
            end
            else
            begin
                want = pending_fields.pop_front();
                if (result.field_x !== want.field_x || result.field_y !== want.field_y
                    || result.field_z !== want.field_z
                    || result.inside_res !== want.inside_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: want x=%0d y=%0d z=%0d in=%0b, got x=%0d y=%0d z=%0d in=%0b",
                                 want.field_x, want.field_y, want.field_z, want.inside_res,
                                 result.field_x, result.field_y, result.field_z,
                                 result.inside_res);
                end
            end
        end
    end

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(in_t w);
        start <= 1'b1;
        cmd <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (w.op == OP_QUERY)
            pending_fields.push_back(predict_field(w));
        else
        begin
            map_bx[w.entry_index] = w.load_bx;
            map_by[w.entry_index] = w.load_by;
            map_bz[w.entry_index] = w.load_bz;
            written[w.entry_index] = 1'b1;
        end
        @(negedge clk);
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(negedge clk);
                burst_left = $urandom_range(0, 10);
            end
            else
                burst_left--;
        end
    endtask

    task automatic send_write(int a, logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
        in_t w;
        w = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w.op = OP_WRITE;
        w.entry_index = 16'(a);
        w.load_bx = bx;
        w.load_by = by;
        w.load_bz = bz;
        send_word(w);
    endtask

    // write any corner of the query cell that has not been written yet
    task automatic send_query(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        in_t w;
        int  ix, iy, iz, fx, fy, fz;
        int  a;
        w = in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        w.op = OP_QUERY;
        w.pos_x = x;
        w.pos_y = y;
        w.pos_z = z;
        if (locate_point(w, ix, iy, iz, fx, fy, fz))
        begin
            for (int k = 0; k < 8; k++)
            begin
                a = (((ix + k[2]) * GY + iy + k[1]) * GZ + iz + k[0]) & 16'hFFFF;
                if (!written[a])
                    send_write(a, $urandom, $urandom, $urandom);
            end
        end
        send_word(w);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending_fields.size() != 0)
            @(negedge clk);
        repeat (40)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'(idx) << 2;
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MIN_X: regs.min_x = v[30:0];
            REG_MIN_Y: regs.min_y = v[30:0];
            REG_MIN_Z: regs.min_z = v;
            REG_INV_X: regs.inv_step_x = v;
            REG_INV_Y: regs.inv_step_y = v;
            REG_INV_Z: regs.inv_step_z = v;
            default: ;
        endcase
    endtask

    task automatic configure(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                             logic [31:0] ix, logic [31:0] iy, logic [31:0] iz);
        drain();
        write_reg(REG_MIN_X, mx);
        write_reg(REG_MIN_Y, my);
        write_reg(REG_MIN_Z, mz);
        write_reg(REG_INV_X, ix);
        write_reg(REG_INV_Y, iy);
        write_reg(REG_INV_Z, iz);
    endtask

    function automatic longint span_of(logic [31:0] inv, int n);
        longint s;
        if (inv == 0)
            return 64'sd2147483647;
        s = (longint'(n - 1) << 16) / longint'(inv);
        return (s > 64'sd2147483647) ? 64'sd2147483647 : s;
    endfunction

    // keep most points in the first few cells so few entries need writing
    function automatic logic [31:0] pick_offset(longint span);
        case ($urandom_range(0, 9))
            0: return span;
            1: return 32'(span + $urandom_range(1, 3));
            2: return 32'($urandom_range(0, 3));
            default: return $urandom_range(0, 32'(span / 16));
        endcase
    endfunction

    function automatic logic [31:0] pick_xy(logic [30:0] mn, logic [31:0] inv, int n);
        longint m;
        if ($urandom_range(0, 15) == 0)
            return $urandom;
        m = longint'(mn) + longint'(pick_offset(span_of(inv, n)));
        if (m >= 64'sd2147483648)
            return 32'h8000_0000;
        return $urandom_range(0, 1) ? 32'(-m) : 32'(m);
    endfunction

    function automatic logic [31:0] pick_z(logic signed [31:0] mn, logic [31:0] inv);
        longint m;
        if ($urandom_range(0, 15) == 0)
            return $urandom;
        m = longint'(mn) + longint'(pick_offset(span_of(inv, GZ)));
        if (m > 64'sd2147483647)
            m = 64'sd2147483647;
        return 32'(m);
    endfunction

    task automatic test_zero_steps();
        configure(0, 0, 0, 0, 0, 0);
        send_query(0, 0, 0);
        send_query(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_query(32'h7FFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFF);
        send_write(0, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_query(5, 6, 7);
    endtask

    task automatic test_unit_steps();
        int c;
        configure(0, 0, 32'hFFFF_8000, 64, 64, 64);
        for (int k = 0; k < 8; k++)
        begin
            c = ((k[2] * GY + k[1]) * GZ + 512 + k[0]);
            send_write(c, k[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
                       k[1] ? 32'h8000_0000 : 32'h7FFF_FFFF, $urandom);
        end
        send_query(512, 512, 32'hFFFF_8000 + 8*1024 + 512);
        send_query(31*1024, -32'sd31*1024, 32'hFFFF_8000 + 63*1024);
        send_query(31*1024 + 16, 0, 0);
        send_query(0, 31*1024 + 16, 0);
        send_query(0, 0, 32'hFFFF_8000 - 1);
        send_query(0, 0, 32'hFFFF_8000 + 63*1024 + 16);
        send_query(32'h8000_0000, 0, 0);
    endtask

    task automatic test_extreme_regs();
        configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_query(32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000);
        send_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001);
        configure(0, 0, 32'h7FFF_FFFF, 1, 1, 1);
        send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_query(0, 0, 32'h8000_0000);
    endtask

    task automatic test_random_phase(int n);
        in_t w;
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                send_write($urandom_range(0, DEPTH - 1), $urandom, $urandom, $urandom);
            else
                send_query(pick_xy(regs.min_x, regs.inv_step_x, GX),
                           pick_xy(regs.min_y, regs.inv_step_y, GY),
                           pick_z(regs.min_z, regs.inv_step_z));
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        regs = '0;
        mismatches = 0;
        cycles = 0;
        burst_left = 0;
        steady = 1'b0;
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_zero_steps();
        test_unit_steps();
        test_extreme_regs();
        configure(0, 0, 32'hFFFF_8000, 64, 64, 64);
        test_random_phase(250);
        configure(1000, 20000, 32'hFFF0_0000, 1000, 77, 6553);
        test_random_phase(200);
        configure($urandom_range(0, 32'h7FFF_0000), $urandom_range(0, 32'h7FFF_0000),
                  $urandom, $urandom_range(1, 200000), $urandom_range(1, 200000),
                  $urandom_range(1, 200000));
        test_random_phase(200);
        configure(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'hFFFF_FFFF, 3, 1);
        test_random_phase(130);
        configure(0, 32'h7FFF_FFFF, 0, 0, 0, 65536);
        test_random_phase(130);
        drain();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
